// ===== src/u8u16_pkg.sv =====
`default_nettype none

package u8u16_pkg;

  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  localparam logic [1:0] PEND_LEAD2 = 2'd1;
  localparam logic [1:0] PEND_LEAD3 = 2'd2;
  localparam logic [1:0] PEND_LEAD4 = 2'd3;

  // one 16-bit unit moving between front, queue and back
  typedef struct packed {
    logic        valid;
    logic [15:0] unit;
  } unit_slot_t;

endpackage

`default_nettype wire

// ===== src/utf8_to_utf16le_stream.sv =====
// UTF-8 to UTF-16LE stream converter.
// Input channel: in_valid / in_stall / in_byte, one UTF-8 byte per item.
// Output channel: out_valid / out_stall / out_byte / unit_done, one output
// byte per item; each 16-bit unit goes out low byte first (unit_done = 0),
// then high byte (unit_done = 1). Carriage returns at a character boundary,
// lead and continuation bytes that only gather, and the tail of a four-byte
// sequence produce nothing.
// The input byte that completes a unit is written into the queue; the back
// end then loads the unit from the queue head and presents its low byte,
// and the high byte follows in the cycle after the low byte is taken.
// Throughput: an input byte is taken every cycle while the two-entry unit
// queue has room; the output port sends one byte a cycle while out_stall is
// low, and each unit takes two bytes, so ASCII input is paced by the output.
// Reset (rst, synchronous) clears the decoder state, empties the queue and
// drops out_valid. When the receiver stalls, the current byte holds, the
// queue fills, and in_stall rises once both queue entries are in use.
`default_nettype none

module utf8_to_utf16le_stream (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            unit_done
);

  u8u16_pkg::unit_slot_t push;
  u8u16_pkg::unit_slot_t head;
  logic                  full;
  logic                  pop;
  logic                  accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  u8u16_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .push    (push)
  );

  u8u16_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (full),
    .head (head)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .unit_done (unit_done)
  );

endmodule

`default_nettype wire

// ===== src/u8u16_front.sv =====
`default_nettype none

module u8u16_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire logic [7:0]             in_byte,
  output u8u16_pkg::unit_slot_t       push
);

  logic [1:0]  bytes_pending, bytes_pending_next;
  logic        discard_mode, discard_mode_next;
  logic [15:0] unit_accum, unit_accum_next;
  logic [1:0]  pend_dec;

  assign pend_dec = bytes_pending - 2'd1;

  always_comb begin
    bytes_pending_next = bytes_pending;
    discard_mode_next  = discard_mode;
    unit_accum_next    = unit_accum;
    push.valid         = 1'b0;
    push.unit          = {8'h00, in_byte};
    if (bytes_pending != 2'd0) begin
      // every byte inside a sequence counts as a continuation
      bytes_pending_next = pend_dec;
      if (discard_mode) begin
        if (pend_dec == 2'd0) discard_mode_next = 1'b0;
      end else begin
        unit_accum_next = {unit_accum[9:0], in_byte[5:0]};
        if (pend_dec == 2'd0) begin
          push.valid = 1'b1;
          push.unit  = unit_accum_next;
        end
      end
    end else begin
      priority if (in_byte == u8u16_pkg::CR_BYTE) begin
        push.valid = 1'b0;
      end else if (in_byte[7] == 1'b0) begin
        push.valid = 1'b1;
      end else if ((in_byte & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_CODE) begin
        unit_accum_next    = {11'd0, in_byte[4:0]};
        bytes_pending_next = u8u16_pkg::PEND_LEAD3;
        discard_mode_next  = 1'b0;
      end else if ((in_byte & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_CODE) begin
        unit_accum_next    = {11'd0, in_byte[4:0]};
        bytes_pending_next = u8u16_pkg::PEND_LEAD2;
        discard_mode_next  = 1'b0;
      end else if ((in_byte & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_CODE) begin
        // four-byte lead goes out as is, its tail is swallowed
        bytes_pending_next = u8u16_pkg::PEND_LEAD4;
        discard_mode_next  = 1'b1;
        push.valid         = 1'b1;
      end else begin
        push.valid = 1'b1;
      end
    end
    if (!accept) push.valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      discard_mode  <= 1'b0;
      unit_accum    <= 16'd0;
    end else if (accept) begin
      bytes_pending <= bytes_pending_next;
      discard_mode  <= discard_mode_next;
      unit_accum    <= unit_accum_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/u8u16_queue.sv =====
`default_nettype none

module u8u16_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire u8u16_pkg::unit_slot_t  push,
  input  wire logic                   pop,
  output logic                        full,
  output u8u16_pkg::unit_slot_t       head
);

  logic [15:0] mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_pop;

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.unit  = mem[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push.valid) mem[wr_ptr] <= push.unit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      unique case ({push.valid, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/u8u16_back.sv =====
`default_nettype none

module u8u16_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire u8u16_pkg::unit_slot_t  head,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [7:0]                  out_byte,
  output logic                        unit_done
);

  logic        busy;
  logic        half;
  logic [15:0] unit;

  // reload as the high byte leaves, so units go out back to back
  assign pop       = head.valid && (!busy || (half && !out_stall));
  assign out_valid = busy;
  assign out_byte  = half ? unit[15:8] : unit[7:0];
  assign unit_done = half;

  always_ff @(posedge clk) begin
    if (pop) unit <= head.unit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      half <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
      half <= 1'b0;
    end else if (busy && !out_stall) begin
      if (half) begin
        busy <= 1'b0;
        half <= 1'b0;
      end else begin
        half <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/u8u16_checker.sv =====
`default_nettype none

module u8u16_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] in_byte,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       unit_done
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_byte))
    else $error("stalled input item changed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_byte) && $stable(unit_done))
    else $error("stalled output item changed");

  // the high byte follows its low byte with no gap
  a_high_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !unit_done |=> out_valid && unit_done)
    else $error("high byte missing after low byte");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind utf8_to_utf16le_stream u8u16_checker u_checker (.*);

`default_nettype wire
